FILE: hdl/packed_bit_field_memory_assert.svh
// Assertion macros shared by the checker of the packed bit field memory.
`ifndef PACKED_BIT_FIELD_MEMORY_ASSERT_SVH
`define PACKED_BIT_FIELD_MEMORY_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PBFM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbfm assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PBFM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbfm assertion failed");

`endif

FILE: hdl/pbfm_pkg.sv
// Package with shared types and constants of the packed bit field memory.
package pbfm_pkg;

    localparam int DEF_WORD_BITS   = 64;
    localparam int DEF_STORE_WORDS = 1024;

    localparam int ADDR_W    = 16;
    localparam int LEN_W     = 7;
    localparam int DATA_W    = 64;
    localparam int KIND_W    = 2;
    localparam int CNT_W     = 7;
    localparam int MAX_FIELD = 64;
    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 1;
    localparam int QUO_W     = 16;
    localparam int RECIP_SH  = 24;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_SET   = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_LOCATE,
        ST_READ,
        ST_MODIFY,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] offset;
        logic [CNT_W-1:0] remain;
    } fu_req_t;

    typedef struct packed {
        logic [CNT_W-1:0]  take;
        logic [DATA_W-1:0] acc;
    } fu_rsp_t;

endpackage

FILE: hdl/pbfm_store.sv
// Single-port word store with registered read data.
module pbfm_store #(
    parameter int WORD_BITS   = pbfm_pkg::DEF_WORD_BITS,
    parameter int STORE_WORDS = pbfm_pkg::DEF_STORE_WORDS,
    localparam int IDX_W      = $clog2(STORE_WORDS)
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     addr,
    input  logic [WORD_BITS-1:0] wdata,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [STORE_WORDS];
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/pbfm_field_unit.sv
// Shared shift and merge unit that handles the part of a field inside one word.
module pbfm_field_unit #(
    parameter int WORD_BITS = pbfm_pkg::DEF_WORD_BITS
) (
    input  logic [WORD_BITS-1:0]      word,
    input  pbfm_pkg::fu_req_t         req,
    input  logic [pbfm_pkg::DATA_W-1:0] value,
    input  logic [pbfm_pkg::DATA_W-1:0] acc,
    output logic [WORD_BITS-1:0]      new_word,
    output pbfm_pkg::fu_rsp_t         rsp
);

    logic [pbfm_pkg::CNT_W-1:0]  avail;
    logic [pbfm_pkg::CNT_W-1:0]  take;
    logic [pbfm_pkg::CNT_W-1:0]  lsb;
    logic [pbfm_pkg::DATA_W-1:0] fmask;
    logic [pbfm_pkg::DATA_W-1:0] ext;
    logic [pbfm_pkg::DATA_W-1:0] chunk;
    logic [WORD_BITS-1:0]        wmask;
    logic [WORD_BITS-1:0]        wfield;

    always_comb begin
        avail    = pbfm_pkg::CNT_W'(WORD_BITS) - req.offset;
        take     = (req.remain < avail) ? req.remain : avail;
        lsb      = avail - take;
        fmask    = {pbfm_pkg::DATA_W{1'b1}} >> (pbfm_pkg::CNT_W'(pbfm_pkg::DATA_W) - take);
        wmask    = fmask[WORD_BITS-1:0] << lsb;
        ext      = pbfm_pkg::DATA_W'((word >> lsb) & fmask[WORD_BITS-1:0]);
        chunk    = (value >> (req.remain - take)) & fmask;
        wfield   = chunk[WORD_BITS-1:0] << lsb;
        new_word = (word & ~wmask) | wfield;
        rsp.take = take;
        rsp.acc  = (acc << take) | ext;
    end

endmodule

FILE: hdl/pbfm_ctrl.sv
// Sequencer that locates a field, walks its words and holds the result word.
module pbfm_ctrl #(
    parameter int WORD_BITS   = pbfm_pkg::DEF_WORD_BITS,
    parameter int STORE_WORDS = pbfm_pkg::DEF_STORE_WORDS,
    localparam int IDX_W      = $clog2(STORE_WORDS)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  pbfm_pkg::kind_t               kind,
    input  logic [pbfm_pkg::ADDR_W-1:0]   bit_address,
    input  logic [pbfm_pkg::LEN_W-1:0]    field_length,
    input  logic [pbfm_pkg::DATA_W-1:0]   write_value,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pbfm_pkg::DATA_W-1:0]   read_data,
    output logic                          range_error,
    output logic                          mem_we,
    output logic [IDX_W-1:0]              mem_addr,
    output logic [WORD_BITS-1:0]          mem_wdata,
    input  logic [WORD_BITS-1:0]          new_word,
    output pbfm_pkg::fu_req_t             fu_req,
    output logic [pbfm_pkg::DATA_W-1:0]   fu_value,
    output logic [pbfm_pkg::DATA_W-1:0]   fu_acc,
    input  pbfm_pkg::fu_rsp_t             fu_rsp
);

    localparam int unsigned TOTAL_BITS = WORD_BITS * STORE_WORDS;
    localparam int RECIP_W = 22;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << pbfm_pkg::RECIP_SH) + WORD_BITS - 1) / WORD_BITS);
    localparam int PROD_W = pbfm_pkg::RECIP_SH + pbfm_pkg::QUO_W;

    pbfm_pkg::state_t              state_reg, state_next;
    logic [IDX_W-1:0]              clr_reg, clr_next;
    logic [pbfm_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [pbfm_pkg::CNT_W-1:0]    rem_reg, rem_next;
    logic [pbfm_pkg::CNT_W-1:0]    off_reg, off_next;
    logic [pbfm_pkg::DATA_W-1:0]   val_reg, val_next;
    logic [pbfm_pkg::DATA_W-1:0]   acc_reg, acc_next;
    logic                          wr_reg, wr_next;
    logic                          err_reg, err_next;
    logic [pbfm_pkg::QUO_W-1:0]    quo_reg, quo_next;
    logic [IDX_W-1:0]              word_reg, word_next;
    logic                          m_valid_reg, m_valid_next;
    logic [pbfm_pkg::DATA_W-1:0]   m_data_reg, m_data_next;
    logic                          m_err_reg, m_err_next;

    logic [pbfm_pkg::LEN_W-1:0]    len_eff;
    logic                          in_err;
    logic [PROD_W-1:0]             prod;
    logic [pbfm_pkg::QUO_W-1:0]    quo_base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pbfm_pkg::ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        rem_reg    <= rem_next;
        off_reg    <= off_next;
        val_reg    <= val_next;
        acc_reg    <= acc_next;
        wr_reg     <= wr_next;
        err_reg    <= err_next;
        quo_reg    <= quo_next;
        word_reg   <= word_next;
        m_data_reg <= m_data_next;
        m_err_reg  <= m_err_next;
    end

    always_comb begin
        if (kind == pbfm_pkg::KIND_SET || kind == pbfm_pkg::KIND_CLEAR) begin
            len_eff = pbfm_pkg::LEN_W'(1);
        end else if (field_length > pbfm_pkg::LEN_W'(pbfm_pkg::MAX_FIELD)) begin
            len_eff = pbfm_pkg::LEN_W'(pbfm_pkg::MAX_FIELD);
        end else begin
            len_eff = field_length;
        end
        in_err   = (32'(bit_address) + 32'(len_eff)) > 32'(TOTAL_BITS);
        prod     = PROD_W'(addr_reg) * PROD_W'(RECIP);
        quo_base = quo_reg * pbfm_pkg::QUO_W'(WORD_BITS);
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        addr_next    = addr_reg;
        rem_next     = rem_reg;
        off_next     = off_reg;
        val_next     = val_reg;
        acc_next     = acc_reg;
        wr_next      = wr_reg;
        err_next     = err_reg;
        quo_next     = quo_reg;
        word_next    = word_reg;
        m_data_next  = m_data_reg;
        m_err_next   = m_err_reg;
        m_valid_next = m_valid_reg && !m_tready;
        mem_we       = 1'b0;
        mem_addr     = word_reg;
        mem_wdata    = new_word;

        case (state_reg)
            pbfm_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(STORE_WORDS - 1)) begin
                    state_next = pbfm_pkg::ST_IDLE;
                end
            end
            pbfm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    addr_next = bit_address;
                    rem_next  = len_eff;
                    off_next  = '0;
                    acc_next  = '0;
                    err_next  = in_err;
                    wr_next   = (kind != pbfm_pkg::KIND_READ);
                    if (kind == pbfm_pkg::KIND_WRITE) begin
                        val_next = write_value;
                    end else if (kind == pbfm_pkg::KIND_SET) begin
                        val_next = pbfm_pkg::DATA_W'(1);
                    end else begin
                        val_next = '0;
                    end
                    if (in_err || len_eff == '0) begin
                        state_next = pbfm_pkg::ST_DONE;
                    end else begin
                        state_next = pbfm_pkg::ST_SPLIT;
                    end
                end
            end
            pbfm_pkg::ST_SPLIT: begin
                quo_next   = prod[PROD_W-1:pbfm_pkg::RECIP_SH];
                state_next = pbfm_pkg::ST_LOCATE;
            end
            pbfm_pkg::ST_LOCATE: begin
                word_next  = quo_reg[IDX_W-1:0];
                off_next   = pbfm_pkg::CNT_W'(addr_reg - quo_base);
                state_next = pbfm_pkg::ST_READ;
            end
            pbfm_pkg::ST_READ: begin
                state_next = pbfm_pkg::ST_MODIFY;
            end
            pbfm_pkg::ST_MODIFY: begin
                mem_we = wr_reg;
                if (!wr_reg) begin
                    acc_next = fu_rsp.acc;
                end
                rem_next  = rem_reg - fu_rsp.take;
                off_next  = '0;
                word_next = word_reg + IDX_W'(1);
                if (rem_reg == fu_rsp.take) begin
                    state_next = pbfm_pkg::ST_DONE;
                end else begin
                    state_next = pbfm_pkg::ST_READ;
                end
            end
            pbfm_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = acc_reg;
                    m_err_next   = err_reg;
                    state_next   = pbfm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pbfm_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_tready      = (state_reg == pbfm_pkg::ST_IDLE);
    assign m_tvalid      = m_valid_reg;
    assign read_data     = m_data_reg;
    assign range_error   = m_err_reg;
    assign fu_req.offset = off_reg;
    assign fu_req.remain = rem_reg;
    assign fu_value      = val_reg;
    assign fu_acc        = acc_reg;

endmodule

FILE: hdl/packed_bit_field_memory.sv
// Top level of the packed bit field memory.
//
//   channel | words                  | tdata                       | tuser
//   s_      | read/write/set/clear   | bit_address, length, value | kind
//   m_      | one result per item    | read_data                   | range_error
//
// A flagged or zero-length item goes straight to its result; otherwise the
// field is split and located, and each store word it touches is then read
// and, unless a read, written back in turn through the single store port.
// After reset a clearing pass zeroes all STORE_WORDS store words, with
// s_tready low. A waiting result does not block the next item from entering.
module packed_bit_field_memory #(
    parameter int WORD_BITS   = pbfm_pkg::DEF_WORD_BITS,
    parameter int STORE_WORDS = pbfm_pkg::DEF_STORE_WORDS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // bit_address [15:0], field_length [22:16], write_value [86:23], zero [87]
    input  logic [pbfm_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind [1:0]
    input  logic [pbfm_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_data [63:0]
    output logic [pbfm_pkg::M_TDATA_W-1:0]   m_tdata,
    // range_error [0]
    output logic [pbfm_pkg::M_TUSER_W-1:0]   m_tuser
);

    localparam int IDX_W = $clog2(STORE_WORDS);

    logic                        mem_we;
    logic [IDX_W-1:0]            mem_addr;
    logic [WORD_BITS-1:0]        mem_wdata;
    logic [WORD_BITS-1:0]        mem_rdata;
    logic [WORD_BITS-1:0]        new_word;
    pbfm_pkg::fu_req_t           fu_req;
    pbfm_pkg::fu_rsp_t           fu_rsp;
    logic [pbfm_pkg::DATA_W-1:0] fu_value;
    logic [pbfm_pkg::DATA_W-1:0] fu_acc;
    logic                        range_error;

    pbfm_ctrl #(
        .WORD_BITS   (WORD_BITS),
        .STORE_WORDS (STORE_WORDS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .kind         (pbfm_pkg::kind_t'(s_tuser[1:0])),
        .bit_address  (s_tdata[15:0]),
        .field_length (s_tdata[22:16]),
        .write_value  (s_tdata[86:23]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .read_data    (m_tdata),
        .range_error  (range_error),
        .mem_we       (mem_we),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .new_word     (new_word),
        .fu_req       (fu_req),
        .fu_value     (fu_value),
        .fu_acc       (fu_acc),
        .fu_rsp       (fu_rsp)
    );

    pbfm_field_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_field_unit (
        .word     (mem_rdata),
        .req      (fu_req),
        .value    (fu_value),
        .acc      (fu_acc),
        .new_word (new_word),
        .rsp      (fu_rsp)
    );

    pbfm_store #(
        .WORD_BITS   (WORD_BITS),
        .STORE_WORDS (STORE_WORDS)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign m_tuser = range_error;

endmodule

FILE: hdl/pbfm_checker.sv
// Port checker of the packed bit field memory and its bind to the top level.
`include "packed_bit_field_memory_assert.svh"

module pbfm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pbfm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [pbfm_pkg::M_TUSER_W-1:0] m_tuser
);

    `PBFM_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `PBFM_ASSERT_IMP(a_err_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0)
    `PBFM_ASSERT_NXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind packed_bit_field_memory pbfm_checker u_pbfm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
